>>> hdl/dtof_pkg.sv
// shared types and constants for the ds-twr time of flight block
package dtof_pkg;

  localparam int OUT_BITS   = 49;
  localparam int QUOT_BITS  = 48;
  localparam int NEG_LIMIT  = 200;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO      = 2'd1;
  localparam logic [1:0] ST_BAD_REPLY = 2'd2;
  localparam logic [1:0] ST_TOO_NEG   = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       ovf;
    logic       neg;
  } dtof_ctl_t;

endpackage

>>> hdl/dtof_div_step.sv
// one registered restoring division step, one quotient bit per stage
module dtof_div_step #(
  parameter int DW = 42
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  dtof_pkg::dtof_ctl_t               ctl_in,
  input  logic [DW-1:0]                     den_in,
  input  logic [DW-1:0]                     rem_in,
  input  logic [dtof_pkg::QUOT_BITS-1:0]    low_in,
  input  logic [dtof_pkg::QUOT_BITS-1:0]    quo_in,
  output dtof_pkg::dtof_ctl_t               ctl_out,
  output logic [DW-1:0]                     den_out,
  output logic [DW-1:0]                     rem_out,
  output logic [dtof_pkg::QUOT_BITS-1:0]    low_out,
  output logic [dtof_pkg::QUOT_BITS-1:0]    quo_out
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        take;

  assign trial = {rem_in, low_in[dtof_pkg::QUOT_BITS-1]};
  assign diff  = trial - {1'b0, den_in};
  assign take  = (trial >= {1'b0, den_in});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out.status <= ctl_in.status;
      ctl_out.ovf    <= ctl_in.ovf;
      ctl_out.neg    <= ctl_in.neg;
      den_out        <= den_in;
      rem_out        <= take ? diff[DW-1:0] : trial[DW-1:0];
      low_out        <= {low_in[dtof_pkg::QUOT_BITS-2:0], 1'b0};
      quo_out        <= {quo_in[dtof_pkg::QUOT_BITS-2:0], take};
    end
  end

endmodule

>>> hdl/ds_twr_time_of_flight_top.sv
// top level of the double-sided two-way ranging time of flight pipeline
// usage:
//   in channel: six timestamps of one ranging exchange, taken when in_valid
//   is high and in_stall is low. out channel: flight_time_q8 (signed, with
//   FRACTION_BITS fraction bits) and status, delivered when out_valid is high
//   and out_stall is low. every item gives exactly one result.
//   the pipe has five stages for intervals, split multiplies, product
//   sums, difference and range checks, then 48 restoring division stages (one
//   quotient bit each), then the output register.
//   one item per cycle unless stalled; the division chain sets the depth.
//   the whole pipeline advances together; when the result in the output
//   register is stalled, in_stall rises and every stage holds its item.
//   reset clears all valid bits; no result is shown until an item has gone
//   through the pipe.
//   status: 0 ok, 1 zero interval, 2 reply1 not below round1, 3 tof below
//   -200 ticks; the time of flight is zero on any error and saturates at
//   2^48-1 when too large.
module ds_twr_time_of_flight_top #(
  parameter int TIMESTAMP_BITS = 40,
  parameter int FRACTION_BITS  = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [TIMESTAMP_BITS-1:0]          poll_sent_time,
  input  logic [TIMESTAMP_BITS-1:0]          poll_heard_time,
  input  logic [TIMESTAMP_BITS-1:0]          response_sent_time,
  input  logic [TIMESTAMP_BITS-1:0]          response_heard_time,
  input  logic [TIMESTAMP_BITS-1:0]          final_sent_time,
  input  logic [TIMESTAMP_BITS-1:0]          final_heard_time,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dtof_pkg::OUT_BITS-1:0] flight_time_q8,
  output logic [1:0]                         status
);

  localparam int TB  = TIMESTAMP_BITS;
  localparam int QB  = dtof_pkg::QUOT_BITS;
  localparam int HB  = (TB + 1) / 2;
  localparam int LB  = TB - HB;
  localparam int PW  = 2 * TB;
  localparam int DW  = TB + 2;
  localparam int NW  = PW + FRACTION_BITS;
  localparam int CW0 = (NW > DW + QB) ? NW : DW + QB;
  localparam int CW  = CW0 + 1;
  localparam int LW  = DW + 8;
  localparam int MW  = (PW > LW) ? PW + 1 : LW + 1;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // stage 1: intervals and early checks
  logic [TB-1:0] round1_c, reply1_c, round2_c, reply2_c;
  assign round1_c = response_heard_time - poll_sent_time;
  assign reply1_c = response_sent_time - poll_heard_time;
  assign round2_c = final_heard_time - response_sent_time;
  assign reply2_c = final_sent_time - response_heard_time;

  logic          v1;
  logic [1:0]    st1;
  logic [TB-1:0] round1, reply1, round2, reply2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      round1 <= round1_c;
      reply1 <= reply1_c;
      round2 <= round2_c;
      reply2 <= reply2_c;
      if (round1_c == '0 || reply1_c == '0 || round2_c == '0 || reply2_c == '0) begin
        st1 <= dtof_pkg::ST_ZERO;
      end else if (reply1_c >= round1_c) begin
        st1 <= dtof_pkg::ST_BAD_REPLY;
      end else begin
        st1 <= dtof_pkg::ST_OK;
      end
    end
  end

  // stage 2: split partial products
  logic           v2;
  logic [1:0]     st2;
  logic [DW-1:0]  den2;
  logic [2*HB-1:0] a_ll, b_ll;
  logic [HB+LB-1:0] a_lh, a_hl, b_lh, b_hl;
  logic [2*LB-1:0] a_hh, b_hh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2  <= st1;
      den2 <= DW'(round1) + DW'(round2) + DW'(reply1) + DW'(reply2);
      a_ll <= round1[HB-1:0] * round2[HB-1:0];
      a_lh <= round1[HB-1:0] * round2[TB-1:HB];
      a_hl <= round1[TB-1:HB] * round2[HB-1:0];
      a_hh <= round1[TB-1:HB] * round2[TB-1:HB];
      b_ll <= reply1[HB-1:0] * reply2[HB-1:0];
      b_lh <= reply1[HB-1:0] * reply2[TB-1:HB];
      b_hl <= reply1[TB-1:HB] * reply2[HB-1:0];
      b_hh <= reply1[TB-1:HB] * reply2[TB-1:HB];
    end
  end

  // stage 3: full products
  logic          v3;
  logic [1:0]    st3;
  logic [DW-1:0] den3;
  logic [PW-1:0] pa, pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3  <= st2;
      den3 <= den2;
      pa   <= (PW'(a_hh) << (2 * HB)) + (PW'(a_lh) << HB) + (PW'(a_hl) << HB) + PW'(a_ll);
      pb   <= (PW'(b_hh) << (2 * HB)) + (PW'(b_lh) << HB) + (PW'(b_hl) << HB) + PW'(b_ll);
    end
  end

  // stage 4: magnitude of the difference and the negative limit
  logic          v4;
  logic [1:0]    st4;
  logic          neg4;
  logic [PW-1:0] mag4;
  logic [DW-1:0] den4;
  logic [LW-1:0] lim4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st4  <= st3;
      den4 <= den3;
      neg4 <= (pa < pb);
      mag4 <= (pa < pb) ? (pb - pa) : (pa - pb);
      lim4 <= LW'(den3) * LW'(dtof_pkg::NEG_LIMIT);
    end
  end

  // stage 5: range checks and division setup
  logic [CW-1:0] num_ext;
  logic [CW-1:0] den_top;
  logic          too_neg;
  assign num_ext = CW'(mag4) << FRACTION_BITS;
  assign den_top = CW'(den4) << QB;
  assign too_neg = neg4 && (MW'(lim4) < MW'(mag4));

  dtof_pkg::dtof_ctl_t ctl_d [0:QB];
  logic [DW-1:0]       den_d [0:QB];
  logic [DW-1:0]       rem_d [0:QB];
  logic [QB-1:0]       low_d [0:QB];
  logic [QB-1:0]       quo_d [0:QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d[0].valid <= 1'b0;
    end else if (en) begin
      ctl_d[0].valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (st4 == dtof_pkg::ST_OK && too_neg) begin
        ctl_d[0].status <= dtof_pkg::ST_TOO_NEG;
      end else begin
        ctl_d[0].status <= st4;
      end
      ctl_d[0].ovf <= !neg4 && (num_ext >= den_top);
      ctl_d[0].neg <= neg4;
      den_d[0]     <= den4;
      rem_d[0]     <= num_ext[QB +: DW];
      low_d[0]     <= num_ext[QB-1:0];
      quo_d[0]     <= '0;
    end
  end

  // division chain
  for (genvar k = 0; k < QB; k++) begin : g_div
    dtof_div_step #(.DW(DW)) u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctl_in  (ctl_d[k]),
      .den_in  (den_d[k]),
      .rem_in  (rem_d[k]),
      .low_in  (low_d[k]),
      .quo_in  (quo_d[k]),
      .ctl_out (ctl_d[k+1]),
      .den_out (den_d[k+1]),
      .rem_out (rem_d[k+1]),
      .low_out (low_d[k+1]),
      .quo_out (quo_d[k+1])
    );
  end

  // output register
  logic [dtof_pkg::OUT_BITS-1:0] q_ext;
  logic [dtof_pkg::OUT_BITS-1:0] flight_next;
  assign q_ext = {1'b0, quo_d[QB]};

  always_comb begin
    if (ctl_d[QB].status != dtof_pkg::ST_OK) begin
      flight_next = '0;
    end else if (ctl_d[QB].ovf) begin
      flight_next = {1'b0, {QB{1'b1}}};
    end else if (ctl_d[QB].neg) begin
      flight_next = '0 - q_ext;
    end else begin
      flight_next = q_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl_d[QB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      flight_time_q8 <= flight_next;
      status         <= ctl_d[QB].status;
    end
  end

endmodule
